// ===== design/v3acc_pkg.sv =====
// Shared constants, command types and saturation helper for the vector accumulator.
`timescale 1ns / 1ps

package v3acc_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_BITS = 32;
    localparam int ACC_BITS   = (WORD_BITS > FIELD_BITS) ? FIELD_BITS : WORD_BITS;
    localparam int PROD_BITS  = 2 * FIELD_BITS;
    localparam int TERM_BITS  = PROD_BITS + 1;
    localparam int NUM_BITS   = FIELD_BITS + FRAC_BITS;
    localparam int WIDE_BITS  = (TERM_BITS > NUM_BITS) ? TERM_BITS + 1 : NUM_BITS + 1;
    localparam int CNT_BITS   = $clog2(NUM_BITS + 2);

    localparam logic signed [WIDE_BITS-1:0] ACC_MAX_W =
        {{(WIDE_BITS - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [WIDE_BITS-1:0] ACC_MIN_W = ~ACC_MAX_W;
    localparam logic signed [WIDE_BITS-1:0] HALF_W =
        WIDE_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        FUNC_LOAD,
        FUNC_ADD,
        FUNC_CROSS,
        FUNC_NORM
    } func_t;

    typedef enum logic [3:0] {
        MUL_AY_BZ,
        MUL_AZ_BY,
        MUL_AZ_BX,
        MUL_AX_BZ,
        MUL_AX_BY,
        MUL_AY_BX,
        MUL_XX,
        MUL_YY,
        MUL_ZZ
    } mul_sel_t;

    typedef enum logic [1:0] {
        TERM_HOLD,
        TERM_LOAD,
        TERM_SUB,
        TERM_ADD
    } term_op_t;

    typedef struct packed {
        logic       capture;
        logic       simple_en;
        logic       simple_add;
        mul_sel_t   mul_sel;
        term_op_t   term_op;
        logic       cross_commit;
        logic [1:0] commit_idx;
        logic       cross_write;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       div_commit;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic                sat;
        logic [ACC_BITS-1:0] val;
    } clip_t;

    function automatic clip_t clip_fn(input logic signed [WIDE_BITS-1:0] v);
        clip_t r;
        if (v > ACC_MAX_W) begin
            r.sat = 1'b1;
            r.val = ACC_MAX_W[ACC_BITS-1:0];
        end else if (v < ACC_MIN_W) begin
            r.sat = 1'b1;
            r.val = ACC_MIN_W[ACC_BITS-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = v[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/vector3_accumulator_unit.sv =====
// Top level of the Q16.16 three-component vector accumulator.
`timescale 1ns / 1ps

// One request at a time: load or add runs S_SIMPLE then S_FINISH, cross product runs
// six products through one shared 32x32 multiplier, normalize runs squares on the same
// multiplier, a 32-step bit-serial square root, then three 48-step restoring dividers
// running side by side; normalize of a zero vector goes straight to S_FINISH. A finished
// result sits in an output register, so the next request is accepted while it waits; a
// result only holds back the end of the following request.
module vector3_accumulator_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_func,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_x,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_y,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_x,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_y,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_z,
    output logic                                  m_saturated
);
    import v3acc_pkg::*;

    cmd_t cmd;
    logic acc_zero;

    v3acc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (func_t'(s_func)),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .acc_zero (acc_zero),
        .cmd      (cmd)
    );

    v3acc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_in_x      (s_in_x),
        .s_in_y      (s_in_y),
        .s_in_z      (s_in_z),
        .acc_zero    (acc_zero),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_saturated (m_saturated)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a previous one is in progress");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten before being taken");

    a_capture_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (s_valid && s_ready))
        else $error("operand captured without an accepted request");
`endif

endmodule

// ===== design/v3acc_datapath.sv =====
// Datapath: vector registers, shared multiplier, bit-serial square root and three dividers.
`timescale 1ns / 1ps

module v3acc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  v3acc_pkg::cmd_t                      cmd,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_x,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_y,
    input  logic signed [v3acc_pkg::FIELD_BITS-1:0] s_in_z,
    output logic                                 acc_zero,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_x,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_y,
    output logic signed [v3acc_pkg::FIELD_BITS-1:0] m_out_z,
    output logic                                 m_saturated
);
    import v3acc_pkg::*;

    logic signed [ACC_BITS-1:0]   acc_reg [3];
    logic signed [ACC_BITS-1:0]   new_reg [3];
    logic signed [FIELD_BITS-1:0] b_reg [3];
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [TERM_BITS-1:0]  term_reg;
    logic                         sat_reg;
    logic [PROD_BITS-1:0]         n_reg, root_reg, bit_reg;
    logic [FIELD_BITS:0]          rem_reg [3];
    logic [NUM_BITS-1:0]          quo_reg [3];
    logic signed [FIELD_BITS-1:0] out_reg [3];
    logic                         out_sat_reg;

    logic signed [FIELD_BITS-1:0] acc_ext [3];
    logic [FIELD_BITS-1:0]        mag [3];
    logic signed [FIELD_BITS-1:0] mul_a, mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;
    logic signed [WIDE_BITS-1:0]  rescaled;
    clip_t                        cross_clip;
    clip_t                        simple_clip [3];
    clip_t                        div_clip [3];
    logic [PROD_BITS-1:0]         root_trial;
    logic [FIELD_BITS-1:0]        len;
    logic [FIELD_BITS:0]          rem_sh [3];
    logic [FIELD_BITS+1:0]        rem_diff [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_ext[i] = FIELD_BITS'(acc_reg[i]);
            mag[i] = acc_ext[i][FIELD_BITS-1] ? FIELD_BITS'(-acc_ext[i]) : acc_ext[i];
            simple_clip[i] = clip_fn(cmd.simple_add
                ? WIDE_BITS'(acc_ext[i]) + WIDE_BITS'(b_reg[i])
                : WIDE_BITS'(b_reg[i]));
            rem_sh[i] = {rem_reg[i][FIELD_BITS-1:0], quo_reg[i][NUM_BITS-1]};
            rem_diff[i] = {1'b0, rem_sh[i]} - {2'b00, len};
            div_clip[i] = clip_fn(acc_ext[i][FIELD_BITS-1]
                ? -signed'(WIDE_BITS'(quo_reg[i]))
                : signed'(WIDE_BITS'(quo_reg[i])));
        end
    end

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_AY_BZ: begin mul_a = acc_ext[1]; mul_b = b_reg[2]; end
            MUL_AZ_BY: begin mul_a = acc_ext[2]; mul_b = b_reg[1]; end
            MUL_AZ_BX: begin mul_a = acc_ext[2]; mul_b = b_reg[0]; end
            MUL_AX_BZ: begin mul_a = acc_ext[0]; mul_b = b_reg[2]; end
            MUL_AX_BY: begin mul_a = acc_ext[0]; mul_b = b_reg[1]; end
            MUL_AY_BX: begin mul_a = acc_ext[1]; mul_b = b_reg[0]; end
            MUL_XX:    begin mul_a = acc_ext[0]; mul_b = acc_ext[0]; end
            MUL_YY:    begin mul_a = acc_ext[1]; mul_b = acc_ext[1]; end
            MUL_ZZ:    begin mul_a = acc_ext[2]; mul_b = acc_ext[2]; end
            default:   begin mul_a = acc_ext[0]; mul_b = b_reg[0]; end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign rescaled   = (WIDE_BITS'(term_reg) + HALF_W) >>> FRAC_BITS;
    assign cross_clip = clip_fn(rescaled);
    assign root_trial = root_reg + bit_reg;
    assign len        = root_reg[FIELD_BITS-1:0];
    assign acc_zero   = (acc_reg[0] == '0) && (acc_reg[1] == '0) && (acc_reg[2] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (cmd.simple_en) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= simple_clip[i].val;
            end
        end else if (cmd.cross_write) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= new_reg[i];
            end
        end else if (cmd.div_commit) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= div_clip[i].val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            b_reg[0] <= s_in_x;
            b_reg[1] <= s_in_y;
            b_reg[2] <= s_in_z;
            sat_reg  <= 1'b0;
        end else if (cmd.simple_en) begin
            sat_reg <= simple_clip[0].sat | simple_clip[1].sat | simple_clip[2].sat;
        end else if (cmd.cross_commit) begin
            sat_reg <= sat_reg | cross_clip.sat;
        end else if (cmd.div_commit) begin
            sat_reg <= div_clip[0].sat | div_clip[1].sat | div_clip[2].sat;
        end

        if (cmd.cross_commit) begin
            new_reg[cmd.commit_idx] <= cross_clip.val;
        end

        prod_reg <= mul_p;

        unique case (cmd.term_op)
            TERM_HOLD: term_reg <= term_reg;
            TERM_LOAD: term_reg <= TERM_BITS'(prod_reg);
            TERM_SUB:  term_reg <= term_reg - TERM_BITS'(prod_reg);
            TERM_ADD:  term_reg <= term_reg + TERM_BITS'(prod_reg);
        endcase

        if (cmd.root_init) begin
            n_reg    <= term_reg[PROD_BITS-1:0];
            root_reg <= '0;
            bit_reg  <= PROD_BITS'(1) << (PROD_BITS - 2);
        end else if (cmd.root_step) begin
            if (n_reg >= root_trial) begin
                n_reg    <= n_reg - root_trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        for (int i = 0; i < 3; i++) begin
            if (cmd.div_init) begin
                rem_reg[i] <= '0;
                quo_reg[i] <= {mag[i], {FRAC_BITS{1'b0}}};
            end else if (cmd.div_step) begin
                if (!rem_diff[i][FIELD_BITS+1]) begin
                    rem_reg[i] <= rem_diff[i][FIELD_BITS:0];
                    quo_reg[i] <= {quo_reg[i][NUM_BITS-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= rem_sh[i];
                    quo_reg[i] <= {quo_reg[i][NUM_BITS-2:0], 1'b0};
                end
            end
        end

        if (cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= acc_ext[i];
            end
            out_sat_reg <= sat_reg;
        end
    end

    assign m_out_x     = out_reg[0];
    assign m_out_y     = out_reg[1];
    assign m_out_z     = out_reg[2];
    assign m_saturated = out_sat_reg;

endmodule

// ===== design/v3acc_ctrl.sv =====
// Controller: sequences each request's operation and the result handshake.
`timescale 1ns / 1ps

module v3acc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  v3acc_pkg::func_t       s_func,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   acc_zero,
    output v3acc_pkg::cmd_t        cmd
);
    import v3acc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIMPLE,
        S_CROSS,
        S_SQUARE,
        S_ROOT,
        S_DIV,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    func_t               func_reg, func_next;
    logic                m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg + CNT_BITS'(1);
        func_next    = func_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_AY_BZ;
        cmd.term_op  = TERM_HOLD;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    func_next   = s_func;
                    unique case (s_func)
                        FUNC_LOAD, FUNC_ADD: state_next = S_SIMPLE;
                        FUNC_CROSS:          state_next = S_CROSS;
                        FUNC_NORM:           state_next = acc_zero ? S_FINISH : S_SQUARE;
                    endcase
                end
            end
            S_SIMPLE: begin
                cmd.simple_en  = 1'b1;
                cmd.simple_add = (func_reg == FUNC_ADD);
                state_next     = S_FINISH;
            end
            S_CROSS: begin
                unique case (cnt_reg)
                    CNT_BITS'(0): cmd.mul_sel = MUL_AY_BZ;
                    CNT_BITS'(1): cmd.mul_sel = MUL_AZ_BY;
                    CNT_BITS'(2): cmd.mul_sel = MUL_AZ_BX;
                    CNT_BITS'(3): cmd.mul_sel = MUL_AX_BZ;
                    CNT_BITS'(4): cmd.mul_sel = MUL_AX_BY;
                    CNT_BITS'(5): cmd.mul_sel = MUL_AY_BX;
                    default:      cmd.mul_sel = MUL_AY_BZ;
                endcase
                if (cnt_reg >= CNT_BITS'(1) && cnt_reg <= CNT_BITS'(6)) begin
                    cmd.term_op = cnt_reg[0] ? TERM_LOAD : TERM_SUB;
                end
                if (cnt_reg >= CNT_BITS'(3) && cnt_reg <= CNT_BITS'(7) && cnt_reg[0]) begin
                    cmd.cross_commit = 1'b1;
                    cmd.commit_idx   = 2'(cnt_reg - CNT_BITS'(3) >> 1);
                end
                if (cnt_reg == CNT_BITS'(8)) begin
                    cmd.cross_write = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_SQUARE: begin
                unique case (cnt_reg)
                    CNT_BITS'(0): cmd.mul_sel = MUL_XX;
                    CNT_BITS'(1): cmd.mul_sel = MUL_YY;
                    CNT_BITS'(2): cmd.mul_sel = MUL_ZZ;
                    default:      cmd.mul_sel = MUL_XX;
                endcase
                if (cnt_reg == CNT_BITS'(1)) begin
                    cmd.term_op = TERM_LOAD;
                end else if (cnt_reg == CNT_BITS'(2) || cnt_reg == CNT_BITS'(3)) begin
                    cmd.term_op = TERM_ADD;
                end
                if (cnt_reg == CNT_BITS'(4)) begin
                    cmd.root_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_ROOT;
                end
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_BITS'(FIELD_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (cnt_reg == '0) begin
                    cmd.div_init = 1'b1;
                end else if (cnt_reg == CNT_BITS'(NUM_BITS + 1)) begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_FINISH;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            func_reg    <= FUNC_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            func_reg    <= func_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== tb/tb_vector3_accumulator_unit.sv =====
// Testbench for the Q16.16 vector accumulator: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module tb_vector3_accumulator_unit;
    import v3acc_pkg::*;

    typedef struct {
        func_t       func;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
    } vec_req_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } vec_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic signed [31:0] s_in_x, s_in_y, s_in_z;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic        m_saturated;

    vec_req_t pending_reqs[$];
    vec_res_t expected_vecs[$];
    longint   vec_x, vec_y, vec_z;
    int       errors;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       req_taken;

    vector3_accumulator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_in_x(s_in_x), .s_in_y(s_in_y), .s_in_z(s_in_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_saturated(m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint clip_acc(input longint v, inout bit sat);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (ACC_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // exact 65-bit difference, round half up, arithmetic shift
    function automatic longint round_rescale(input logic signed [66:0] d);
        logic signed [66:0] r;
        r = (d + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 67'sh7fffffffffffffff) return 64'sh7fffffffffffffff;
        if (r < -67'sh8000000000000000) return 64'sh8000000000000000;
        return longint'(r);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint unit_scale(input longint a, input logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        m = (a < 0) ? 64'(-a) : 64'(a);
        q = (m << FRAC_BITS) / len;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic vec_res_t apply_vec_op(input vec_req_t r);
        vec_res_t o;
        bit sat;
        longint bx, by, bz, nx, ny, nz;
        logic [63:0] len;
        logic signed [66:0] ax, ay, az, cx, cy, cz;
        sat = 1'b0;
        bx = longint'($signed(r.bx));
        by = longint'($signed(r.by));
        bz = longint'($signed(r.bz));
        case (r.func)
            FUNC_LOAD: begin
                vec_x = clip_acc(bx, sat);
                vec_y = clip_acc(by, sat);
                vec_z = clip_acc(bz, sat);
            end
            FUNC_ADD: begin
                vec_x = clip_acc(vec_x + bx, sat);
                vec_y = clip_acc(vec_y + by, sat);
                vec_z = clip_acc(vec_z + bz, sat);
            end
            FUNC_CROSS: begin
                ax = vec_x; ay = vec_y; az = vec_z;
                cx = bx; cy = by; cz = bz;
                nx = round_rescale(ay * cz - az * cy);
                ny = round_rescale(az * cx - ax * cz);
                nz = round_rescale(ax * cy - ay * cx);
                vec_x = clip_acc(nx, sat);
                vec_y = clip_acc(ny, sat);
                vec_z = clip_acc(nz, sat);
            end
            default: begin
                if (vec_x != 0 || vec_y != 0 || vec_z != 0) begin
                    len = root_floor(64'(vec_x * vec_x) + 64'(vec_y * vec_y)
                                     + 64'(vec_z * vec_z));
                    nx = unit_scale(vec_x, len);
                    ny = unit_scale(vec_y, len);
                    nz = unit_scale(vec_z, len);
                    vec_x = clip_acc(nx, sat);
                    vec_y = clip_acc(ny, sat);
                    vec_z = clip_acc(nz, sat);
                end
            end
        endcase
        o.x = vec_x[31:0];
        o.y = vec_y[31:0];
        o.z = vec_z[31:0];
        o.sat = sat;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic queue_req(input func_t f, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        vec_req_t r;
        r.func = f;
        r.bx = x;
        r.by = y;
        r.bz = z;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (!s_valid || req_taken) begin
                if (req_taken) begin
                    expected_vecs.push_back(apply_vec_op(pending_reqs.pop_front()));
                end
                if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_func <= pending_reqs[0].func;
                    s_in_x <= pending_reqs[0].bx;
                    s_in_y <= pending_reqs[0].by;
                    s_in_z <= pending_reqs[0].bz;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        vec_res_t e;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_vecs.size() == 0) begin
                report_mismatch("unexpected result", m_out_x, 32'h0);
            end else begin
                e = expected_vecs.pop_front();
                if (m_out_x !== e.x) report_mismatch("out_x", m_out_x, e.x);
                if (m_out_y !== e.y) report_mismatch("out_y", m_out_y, e.y);
                if (m_out_z !== e.z) report_mismatch("out_z", m_out_z, e.z);
                if (m_saturated !== e.sat) report_mismatch("saturated", m_saturated, e.sat);
            end
        end
    end

    initial begin
        #20000000;
        $display("vector3_accumulator_unit verification failed");
        $finish;
    end

    initial begin
        int phase;
        int k;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_taken = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = '0;
        s_in_x = '0;
        s_in_y = '0;
        s_in_z = '0;
        m_ready = 1'b0;
        vec_x = 0;
        vec_y = 0;
        vec_z = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero normalize, extremes, overflow of add and cross
        queue_req(FUNC_NORM, 32'h1234, 32'h5678, 32'h9abc);
        queue_req(FUNC_LOAD, 32'h7fffffff, 32'h80000000, 32'h0);
        queue_req(FUNC_ADD, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        queue_req(FUNC_ADD, 32'h80000000, 32'h7fffffff, 32'h1);
        queue_req(FUNC_NORM, 32'h0, 32'h0, 32'h0);
        queue_req(FUNC_LOAD, 32'h00030000, 32'h00040000, 32'h0);
        queue_req(FUNC_NORM, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_req(FUNC_LOAD, 32'h00010000, 32'h0, 32'h0);
        queue_req(FUNC_CROSS, 32'h0, 32'h00010000, 32'h0);
        queue_req(FUNC_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        queue_req(FUNC_CROSS, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        queue_req(FUNC_LOAD, 32'h1, 32'hffffffff, 32'h1);
        queue_req(FUNC_CROSS, 32'h00008000, 32'hffff8000, 32'h00004000);
        queue_req(FUNC_NORM, 32'h0, 32'h0, 32'h0);
        queue_req(FUNC_LOAD, 32'h1, 32'h0, 32'h0);
        queue_req(FUNC_NORM, 32'h0, 32'h0, 32'h0);
        queue_req(FUNC_LOAD, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_req(FUNC_NORM, 32'h0, 32'h0, 32'h0);
        queue_req(FUNC_LOAD, 32'h0, 32'h0, 32'h0);
        queue_req(FUNC_CROSS, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);

        for (phase = 0; phase < 4; phase++) begin
            while (pending_reqs.size() > 0 || s_valid || expected_vecs.size() > 0)
                @(posedge aclk);
            send_idle_pct = (phase == 1 || phase == 3) ? 87 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 87 : 0;
            if (phase == 3) begin
                send_idle_pct = 28;
                recv_stall_pct = 28;
            end
            for (k = 0; k < 385; k++) begin
                if ($urandom_range(0, 3) == 0)
                    queue_req(FUNC_LOAD, rand_comp(), rand_comp(), rand_comp());
                else
                    queue_req(func_t'($urandom_range(0, 3)), rand_comp(), rand_comp(),
                              rand_comp());
            end
        end
        while (pending_reqs.size() > 0 || s_valid || expected_vecs.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("vector3_accumulator_unit verification clean");
        else
            $display("vector3_accumulator_unit verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
design/v3acc_pkg.sv
design/v3acc_datapath.sv
design/v3acc_ctrl.sv
design/vector3_accumulator_unit.sv
tb/tb_vector3_accumulator_unit.sv
